// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers used by the top-level RTL file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked at every clock edge, reset included.
`define ASSERT_CLK_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hdl/prq_pkg.sv =====
// ----------------------------------------------------------------------------
// prq_pkg
// Widths, payload types and helpers of the pose retraction pipeline.
// ----------------------------------------------------------------------------
package prq_pkg;

  localparam int PosW      = 32;
  localparam int LaneW     = 16;
  localparam int QuatW     = 4 * LaneW;
  localparam int ProdW     = 2 * LaneW;
  localparam int SumW      = ProdW + 2;
  localparam int CW        = SumW - 7;
  localparam int SqW       = 51;
  localparam int NormW     = 53;
  localparam int RootSteps = 27;
  localparam int RootW     = 27;
  localparam int QuotW     = 16;
  localparam int NumW      = RootW + 15;

  typedef struct packed {
    logic [PosW-1:0] px;
    logic [PosW-1:0] py;
    logic [PosW-1:0] pz;
  } pos_t;

  typedef struct packed {
    pos_t                 pos;
    logic [3:0][CW-1:0]   c;
  } carry_t;

  function automatic logic [PosW-1:0] sat_add(input logic [PosW-1:0] a,
                                              input logic [PosW-1:0] b);
    logic [PosW:0] s;
    s = {a[PosW-1], a} + {b[PosW-1], b};
    if (s[PosW] != s[PosW-1]) begin
      sat_add = s[PosW] ? {1'b1, {(PosW-1){1'b0}}} : {1'b0, {(PosW-1){1'b1}}};
    end else begin
      sat_add = s[PosW-1:0];
    end
  endfunction

endpackage

// ===== hdl/pose_quaternion_retract.sv =====
// ----------------------------------------------------------------------------
// pose_quaternion_retract
// Pose update: saturating position step and renormalized q * [1, theta/2].
// ----------------------------------------------------------------------------
// The block takes one request per cycle while in_stall is low. The stages
// are four for the products and the squared norm, 27 of the square root
// (one root bit each), and 18 of the four-lane divider with its output
// register. The whole pipeline advances together; while a finished result
// is held by out_stall, in_stall is high.
`include "assert_macros.svh"

module pose_quaternion_retract (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [prq_pkg::PosW-1:0]   pos_x,
  input  logic [prq_pkg::PosW-1:0]   pos_y,
  input  logic [prq_pkg::PosW-1:0]   pos_z,
  input  logic [prq_pkg::QuatW-1:0]  quat_in,
  input  logic [prq_pkg::PosW-1:0]   step_x,
  input  logic [prq_pkg::PosW-1:0]   step_y,
  input  logic [prq_pkg::PosW-1:0]   step_z,
  input  logic [prq_pkg::LaneW-1:0]  rot_x,
  input  logic [prq_pkg::LaneW-1:0]  rot_y,
  input  logic [prq_pkg::LaneW-1:0]  rot_z,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [prq_pkg::PosW-1:0]   new_pos_x,
  output logic [prq_pkg::PosW-1:0]   new_pos_y,
  output logic [prq_pkg::PosW-1:0]   new_pos_z,
  output logic [prq_pkg::QuatW-1:0]  quat_out
);
  import prq_pkg::*;

  logic             en;
  logic             p_valid, r_valid;
  carry_t           p_data, r_data;
  logic [NormW-1:0] p_norm;
  logic [RootW-1:0] r_root;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  prq_product u_product (
    .clk, .rst, .en, .in_valid,
    .pos_x, .pos_y, .pos_z, .quat_in,
    .step_x, .step_y, .step_z,
    .rot_x, .rot_y, .rot_z,
    .o_valid (p_valid),
    .o_data  (p_data),
    .o_norm  (p_norm)
  );

  prq_sqrt u_sqrt (
    .clk, .rst, .en,
    .i_valid (p_valid),
    .i_data  (p_data),
    .i_norm  (p_norm),
    .o_valid (r_valid),
    .o_data  (r_data),
    .o_root  (r_root)
  );

  prq_div u_div (
    .clk, .rst, .en,
    .i_valid (r_valid),
    .i_data  (r_data),
    .i_root  (r_root),
    .out_valid,
    .new_pos_x, .new_pos_y, .new_pos_z,
    .quat_out
  );

  // The input is held back only by a result waiting at the output.
  `ASSERT_CLK(a_stall_cause, clk, rst, in_stall |-> (out_valid && out_stall), "stall without cause")
  // Reset empties the pipeline, so nothing comes out right after it.
  `ASSERT_CLK_ALWAYS(a_reset_empty, clk, rst |=> !out_valid, "result after reset")
  // A frozen pipeline keeps the item at the root output in place.
  `ASSERT_CLK(a_freeze, clk, rst, (out_valid && out_stall) |=> $stable(r_valid), "stage moved in stall")

endmodule

// ===== hdl/prq_product.sv =====
// ----------------------------------------------------------------------------
// prq_product
// Position sums, Hamilton product lanes and squared norm over four stages.
// ----------------------------------------------------------------------------
module prq_product (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [prq_pkg::PosW-1:0] pos_x,
  input  logic [prq_pkg::PosW-1:0] pos_y,
  input  logic [prq_pkg::PosW-1:0] pos_z,
  input  logic [prq_pkg::QuatW-1:0] quat_in,
  input  logic [prq_pkg::PosW-1:0] step_x,
  input  logic [prq_pkg::PosW-1:0] step_y,
  input  logic [prq_pkg::PosW-1:0] step_z,
  input  logic [prq_pkg::LaneW-1:0] rot_x,
  input  logic [prq_pkg::LaneW-1:0] rot_y,
  input  logic [prq_pkg::LaneW-1:0] rot_z,
  output logic                     o_valid,
  output prq_pkg::carry_t          o_data,
  output logic [prq_pkg::NormW-1:0] o_norm
);
  import prq_pkg::*;

  logic [3:0]               valid;
  pos_t                     pos1;
  logic [3:0][2:0][ProdW-1:0] prod;
  logic [3:0][LaneW-1:0]    base;
  carry_t                   d2, d3;
  logic [3:0][SqW-1:0]      sq;
  logic [NormW-1:0]         norm;

  logic signed [LaneW-1:0] qx, qy, qz, qw, vx, vy, vz;
  logic [3:0][CW-1:0]      c_next;

  assign qx = quat_in[LaneW-1:0];
  assign qy = quat_in[2*LaneW-1:LaneW];
  assign qz = quat_in[3*LaneW-1:2*LaneW];
  assign qw = quat_in[4*LaneW-1:3*LaneW];
  assign vx = rot_x;
  assign vy = rot_y;
  assign vz = rot_z;

  // Lane sums with the signs of the product; the raw rotation is v at scale 2^15.
  always_comb begin
    logic signed [SumW-1:0] s [4];
    for (int i = 0; i < 4; i++) begin
      s[i] = SumW'($signed(base[i])) <<< 15;
    end
    s[0] = s[0] + SumW'($signed(prod[0][0])) + SumW'($signed(prod[0][1]))
         - SumW'($signed(prod[0][2]));
    s[1] = s[1] + SumW'($signed(prod[1][0])) - SumW'($signed(prod[1][1]))
         + SumW'($signed(prod[1][2]));
    s[2] = s[2] + SumW'($signed(prod[2][0])) + SumW'($signed(prod[2][1]))
         - SumW'($signed(prod[2][2]));
    s[3] = s[3] - SumW'($signed(prod[3][0])) - SumW'($signed(prod[3][1]))
         - SumW'($signed(prod[3][2]));
    for (int i = 0; i < 4; i++) begin
      // Division by 128 truncating toward zero.
      c_next[i] = CW'((s[i] + (s[i][SumW-1] ? SumW'(127) : SumW'(0))) >>> 7);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (en) begin
      valid <= {valid[2:0], in_valid};
    end
    if (en) begin
      pos1.px <= sat_add(pos_x, step_x);
      pos1.py <= sat_add(pos_y, step_y);
      pos1.pz <= sat_add(pos_z, step_z);
      prod[0][0] <= ProdW'(qw) * ProdW'(vx);
      prod[0][1] <= ProdW'(qy) * ProdW'(vz);
      prod[0][2] <= ProdW'(qz) * ProdW'(vy);
      prod[1][0] <= ProdW'(qw) * ProdW'(vy);
      prod[1][1] <= ProdW'(qx) * ProdW'(vz);
      prod[1][2] <= ProdW'(qz) * ProdW'(vx);
      prod[2][0] <= ProdW'(qw) * ProdW'(vz);
      prod[2][1] <= ProdW'(qx) * ProdW'(vy);
      prod[2][2] <= ProdW'(qy) * ProdW'(vx);
      prod[3][0] <= ProdW'(qx) * ProdW'(vx);
      prod[3][1] <= ProdW'(qy) * ProdW'(vy);
      prod[3][2] <= ProdW'(qz) * ProdW'(vz);
      base <= {qw, qz, qy, qx};
      d2.pos <= pos1;
      d2.c   <= c_next;
      d3     <= d2;
      for (int i = 0; i < 4; i++) begin
        sq[i] <= SqW'($signed(d2.c[i])) * SqW'($signed(d2.c[i]));
      end
      o_data <= d3;
      norm   <= NormW'(sq[0]) + NormW'(sq[1]) + NormW'(sq[2]) + NormW'(sq[3]);
    end
  end

  assign o_valid = valid[3];
  assign o_norm  = norm;

endmodule

// ===== hdl/prq_sqrt.sv =====
// ----------------------------------------------------------------------------
// prq_sqrt
// Restoring integer square root, one result bit per pipeline stage.
// ----------------------------------------------------------------------------
module prq_sqrt (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      i_valid,
  input  prq_pkg::carry_t           i_data,
  input  logic [prq_pkg::NormW-1:0] i_norm,
  output logic                      o_valid,
  output prq_pkg::carry_t           o_data,
  output logic [prq_pkg::RootW-1:0] o_root
);
  import prq_pkg::*;

  logic [RootSteps:0]  valid;
  carry_t              data [RootSteps+1];
  logic [NormW:0]      rem  [RootSteps+1];
  logic [NormW:0]      res  [RootSteps+1];

  assign valid[0] = i_valid;
  assign data[0]  = i_data;
  assign rem[0]   = {1'b0, i_norm};
  assign res[0]   = '0;

  for (genvar k = 0; k < RootSteps; k++) begin : g_step
    localparam logic [NormW:0] Bit = (NormW+1)'(1) << (NormW - 1 - 2 * k);
    logic [NormW:0] trial;
    logic           take;
    assign trial = res[k] + Bit;
    assign take  = rem[k] >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[k+1] <= 1'b0;
      end else if (en) begin
        valid[k+1] <= valid[k];
      end
      if (en) begin
        data[k+1] <= data[k];
        rem[k+1]  <= take ? rem[k] - trial : rem[k];
        res[k+1]  <= take ? (res[k] >> 1) + Bit : res[k] >> 1;
      end
    end
  end

  assign o_valid = valid[RootSteps];
  assign o_data  = data[RootSteps];
  assign o_root  = res[RootSteps][RootW-1:0];

endmodule

// ===== hdl/prq_div.sv =====
// ----------------------------------------------------------------------------
// prq_div
// Four-lane pipelined restoring divider, rounding, saturation and output.
// ----------------------------------------------------------------------------
module prq_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       i_valid,
  input  prq_pkg::carry_t            i_data,
  input  logic [prq_pkg::RootW-1:0]  i_root,
  output logic                       out_valid,
  output logic [prq_pkg::PosW-1:0]   new_pos_x,
  output logic [prq_pkg::PosW-1:0]   new_pos_y,
  output logic [prq_pkg::PosW-1:0]   new_pos_z,
  output logic [prq_pkg::QuatW-1:0]  quat_out
);
  import prq_pkg::*;

  logic [QuotW:0]              valid;
  pos_t                        pos  [QuotW+1];
  logic [RootW-1:0]            den  [QuotW+1];
  logic [3:0]                  neg  [QuotW+1];
  logic [3:0][NumW-1:0]        rem  [QuotW+1];
  logic [3:0][QuotW-1:0]       quo  [QuotW+1];
  logic [3:0][CW-1:0]          mag0;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mag0[i] = i_data.c[i][CW-1] ? -i_data.c[i] : i_data.c[i];
    end
  end

  // Entry stage: magnitudes and the rounding offset of half the divisor.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid[0] <= 1'b0;
    end else if (en) begin
      valid[0] <= i_valid;
    end
    if (en) begin
      pos[0] <= i_data.pos;
      den[0] <= i_root;
      for (int i = 0; i < 4; i++) begin
        neg[0][i] <= i_data.c[i][CW-1];
        rem[0][i] <= (NumW'(mag0[i]) << 14) + NumW'(i_root >> 1);
        quo[0][i] <= '0;
      end
    end
  end

  for (genvar k = 0; k < QuotW; k++) begin : g_step
    logic [NumW-1:0] dsh;
    assign dsh = NumW'(den[k]) << (QuotW - 1 - k);

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[k+1] <= 1'b0;
      end else if (en) begin
        valid[k+1] <= valid[k];
      end
      if (en) begin
        pos[k+1] <= pos[k];
        den[k+1] <= den[k];
        neg[k+1] <= neg[k];
        for (int i = 0; i < 4; i++) begin
          if (rem[k][i] >= dsh) begin
            rem[k+1][i] <= rem[k][i] - dsh;
            quo[k+1][i] <= {quo[k][i][QuotW-2:0], 1'b1};
          end else begin
            rem[k+1][i] <= rem[k][i];
            quo[k+1][i] <= {quo[k][i][QuotW-2:0], 1'b0};
          end
        end
      end
    end
  end

  logic [QuatW-1:0] packed_next;

  always_comb begin
    logic [QuotW-1:0] q;
    for (int i = 0; i < 4; i++) begin
      q = quo[QuotW][i];
      if (den[QuotW] == '0) begin
        packed_next[i*LaneW +: LaneW] = '0;
      end else if (neg[QuotW][i]) begin
        packed_next[i*LaneW +: LaneW] = (q > 16'd32768) ? 16'h8000 : LaneW'(-q);
      end else begin
        packed_next[i*LaneW +: LaneW] = (q > 16'd32767) ? 16'h7fff : q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= valid[QuotW];
    end
    if (en) begin
      new_pos_x <= pos[QuotW].px;
      new_pos_y <= pos[QuotW].py;
      new_pos_z <= pos[QuotW].pz;
      quat_out  <= packed_next;
    end
  end

endmodule

// ===== tb/tb_pose_quaternion_retract.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pose_quaternion_retract
// Drives pose update requests with random bursts and gaps, stalls the output
// on its own pattern, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module tb_pose_quaternion_retract;
  import prq_pkg::*;

  typedef struct {
    logic [PosW-1:0]  px, py, pz;
    logic [QuatW-1:0] q;
    logic [PosW-1:0]  sx, sy, sz;
    logic [LaneW-1:0] rx, ry, rz;
  } pose_req_t;

  typedef struct {
    logic [PosW-1:0]  px, py, pz;
    logic [QuatW-1:0] q;
  } pose_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [PosW-1:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic [QuatW-1:0] quat_in = '0;
  logic [PosW-1:0] step_x = '0, step_y = '0, step_z = '0;
  logic [LaneW-1:0] rot_x = '0, rot_y = '0, rot_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [PosW-1:0] new_pos_x, new_pos_y, new_pos_z;
  logic [QuatW-1:0] quat_out;

  pose_req_t pending_reqs[$];
  pose_res_t expected_poses[$];
  int errors = 0;
  int cycles = 0;
  bit stim_done = 1'b0;
  bit in_accepted = 1'b0;
  int burst_left = 0;
  int gap_left = 0;
  int hold_off = 0;

  pose_quaternion_retract dut (.*);

  always #5 clk = ~clk;

  function automatic logic [PosW-1:0] clamp_sum(logic [PosW-1:0] a, logic [PosW-1:0] b);
    longint s;
    s = longint'($signed(a)) + longint'($signed(b));
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    if (s < -64'sd2147483648) s = -64'sd2147483648;
    return s[PosW-1:0];
  endfunction

  function automatic logic [63:0] isqrt_floor(logic [63:0] n);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 52;
    for (int i = 0; i < 27; i++) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic pose_res_t retract_pose(pose_req_t r);
    pose_res_t o;
    longint qx, qy, qz, qw, vx, vy, vz, c[4], m, v;
    logic [63:0] n, s, mag, quo;
    qx = longint'($signed(r.q[15:0]));
    qy = longint'($signed(r.q[31:16]));
    qz = longint'($signed(r.q[47:32]));
    qw = longint'($signed(r.q[63:48]));
    vx = longint'($signed(r.rx));
    vy = longint'($signed(r.ry));
    vz = longint'($signed(r.rz));
    o.px = clamp_sum(r.px, r.sx);
    o.py = clamp_sum(r.py, r.sy);
    o.pz = clamp_sum(r.pz, r.sz);
    c[0] = qw * vx + qx * 32768 + qy * vz - qz * vy;
    c[1] = qw * vy - qx * vz + qy * 32768 + qz * vx;
    c[2] = qw * vz + qx * vy - qy * vx + qz * 32768;
    c[3] = qw * 32768 - qx * vx - qy * vy - qz * vz;
    n = 0;
    for (int i = 0; i < 4; i++) begin
      c[i] = c[i] / 128;  // SystemVerilog division truncates toward zero
      m = c[i] < 0 ? -c[i] : c[i];
      n = n + m * m;
    end
    s = isqrt_floor(n);
    o.q = '0;
    if (s != 0) begin
      for (int i = 0; i < 4; i++) begin
        mag = c[i] < 0 ? -c[i] : c[i];
        quo = ((mag << 14) + (s >> 1)) / s;
        v = c[i] < 0 ? -longint'(quo) : longint'(quo);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        o.q[16*i +: 16] = v[15:0];
      end
    end
    return o;
  endfunction

  function automatic logic [LaneW-1:0] pick_lane();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h4000;
      3: return 16'hc000;
      default: return LaneW'($urandom());
    endcase
  endfunction

  function automatic logic [PosW-1:0] pick_pos();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 131071) - 65536;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [LaneW-1:0] pick_rot();
    case ($urandom_range(0, 7))
      0: return pick_lane();
      1: return LaneW'($urandom());
      default: return LaneW'($urandom_range(0, 1023) - 512);  // small angles
    endcase
  endfunction

  task automatic add_req(pose_req_t r);
    pending_reqs.push_back(r);
  endtask

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("ERROR %0t: %s got %h expected %h", $time, what, got, want);
    errors++;
  endtask

  // Directed requests, then random ones.
  initial begin
    pose_req_t r;
    logic [LaneW-1:0] ql[4];
    r = '{default: '0};
    add_req(r);  // zero quaternion: zero norm
    r.q = {16'h4000, 48'h0};
    add_req(r);  // identity, no rotation
    r.px = 32'h7fff_ffff; r.sx = 32'h0000_0001;
    r.py = 32'h8000_0000; r.sy = 32'hffff_ffff;
    r.pz = 32'h7fff_ffff; r.sz = 32'h8000_0000;
    r.rx = 16'h7fff; r.ry = 16'h8000; r.rz = 16'h0100;
    add_req(r);
    r.px = 32'h8000_0000; r.sx = 32'h8000_0000;
    r.py = 32'h7fff_ffff; r.sy = 32'h7fff_ffff;
    r.q = {4{16'h7fff}}; r.rx = 16'h8000; r.ry = 16'h7fff; r.rz = 16'h8000;
    add_req(r);
    r.q = {4{16'h8000}};
    add_req(r);
    r.q = 64'h0001_0000_0000_0000; r.rx = '0; r.ry = '0; r.rz = '0;
    add_req(r);  // tiny non-unit quaternion
    r.q = 64'h0000_0000_0000_4000; r.rx = 16'h2000;
    add_req(r);
    r.q = {16'hc000, 16'h0, 16'h4000, 16'h0}; r.ry = 16'hf000; r.rz = 16'h0800;
    add_req(r);
    r.q = 64'hffff_ffff_ffff_ffff;
    add_req(r);
    r = '{default: '1};
    add_req(r);
    for (int i = 0; i < 1150; i++) begin
      for (int k = 0; k < 4; k++) ql[k] = pick_lane();
      if ($urandom_range(0, 3) != 0) begin
        // Near-unit quaternion with a dominant lane.
        ql[$urandom_range(0, 3)] = $urandom_range(0, 1) ? 16'h3f00 : 16'hc100;
        for (int k = 0; k < 4; k++)
          if (ql[k] != 16'h3f00 && ql[k] != 16'hc100)
            ql[k] = LaneW'($urandom_range(0, 2047) - 1024);
      end
      r.q = {ql[3], ql[2], ql[1], ql[0]};
      r.px = pick_pos(); r.py = pick_pos(); r.pz = pick_pos();
      r.sx = pick_pos(); r.sy = pick_pos(); r.sz = pick_pos();
      r.rx = pick_rot(); r.ry = pick_rot(); r.rz = pick_rot();
      add_req(r);
    end
    stim_done = 1'b1;
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // Remembers whether the request on the bus was taken at the last rising edge.
  always @(posedge clk) begin
    in_accepted <= in_valid && !in_stall;
  end

  // Sender: bursts and gaps, payload held while stalled.
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && !in_accepted) begin
        // hold
      end else begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          pose_req_t r;
          r = pending_reqs.pop_front();
          pos_x <= r.px; pos_y <= r.py; pos_z <= r.pz; quat_in <= r.q;
          step_x <= r.sx; step_y <= r.sy; step_z <= r.sz;
          rot_x <= r.rx; rot_y <= r.ry; rot_z <= r.rz;
          expected_poses.push_back(retract_pose(r));
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(0, 30);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern, with one long hold-off early on.
  always @(negedge clk) begin
    if (!rst) begin
      if (cycles == 300) hold_off <= 200;
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_stall <= 1'b1;
      end else if ((cycles / 500) % 3 == 0) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 3) == 0);
      end
    end
  end

  // Expectations are queued at drive time, so pop only on accepted results.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_poses.size() == 0) begin
        report("unexpected result", quat_out, 64'd0);
      end else begin
        pose_res_t e;
        e = expected_poses.pop_front();
        if (new_pos_x !== e.px) report("new_pos_x", 64'(new_pos_x), 64'(e.px));
        if (new_pos_y !== e.py) report("new_pos_y", 64'(new_pos_y), 64'(e.py));
        if (new_pos_z !== e.pz) report("new_pos_z", 64'(new_pos_z), 64'(e.pz));
        if (quat_out !== e.q) report("quat_out", quat_out, e.q);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 200000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    wait (stim_done);
    wait (pending_reqs.size() == 0 && !in_valid);
    wait (expected_poses.size() == 0);
    repeat (80) @(posedge clk);
    if (errors == 0 && expected_poses.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
